// File: hdl/fscg_pkg.sv
// fscg_pkg: shared constants and types for the scan coordinate generator
// no dependencies
package fscg_pkg;

  localparam int unsigned MaxDimDefault = 32;
  localparam int unsigned CfgWidth = 6;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned IndexWidth = 10;
  localparam int unsigned CoordWidth = 5;
  localparam int unsigned ModeWidth = 4;

  localparam logic [CfgIdxWidth-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_MODE   = 2'd2;

  localparam logic [ModeWidth-1:0] MODE_HORIZ = 4'd0;
  localparam logic [ModeWidth-1:0] MODE_VERT  = 4'd1;
  localparam logic [ModeWidth-1:0] MODE_ZIG   = 4'd2;
  localparam logic [ModeWidth-1:0] MODE_ROW   = 4'd3;
  localparam logic [ModeWidth-1:0] MODE_COL   = 4'd4;
  localparam logic [ModeWidth-1:0] MODE_DIAG  = 4'd5;
  localparam logic [ModeWidth-1:0] MODE_MIRR  = 4'd6;
  localparam logic [ModeWidth-1:0] MODE_BOX   = 4'd7;
  localparam logic [ModeWidth-1:0] MODE_IBOX  = 4'd8;

  // datapath commands from the controller
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_LOAD  = 3'd1,   // latch index and set up for mode
    CMD_STEP  = 3'd2,   // one iteration of division / inverse triangle search
    CMD_EMIT  = 3'd3,   // present current coordinate, advance run
    CMD_PHASE = 3'd4    // switch to second segment of a run
  } cmd_e;

  typedef struct packed {
    logic busy_calc;  // division or search still running
    logic seg_done;   // current segment has no more cells after this one
    logic has_seg2;   // second segment present and non-empty
    logic in_seg2;
    logic error;
    logic single;
  } dp_status_t;

  // input transaction
  typedef struct packed {
    logic [IndexWidth-1:0] scan_index;
  } scan_req_t;

  // output transaction
  typedef struct packed {
    logic [CoordWidth-1:0] coord_row;
    logic [CoordWidth-1:0] coord_col;
    logic                  run_last;
    logic                  index_error;
  } coord_t;

endpackage

// File: hdl/fscg_if.sv
// fscg_if: valid/ready channel interface with a generic payload
// depends on nothing
interface fscg_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/fscg_datapath.sv
// fscg_datapath: index arithmetic, iterative divide / inverse-triangle search, run walker
// depends on fscg_pkg
module fscg_datapath
  import fscg_pkg::*;
#(
  parameter int unsigned MaxDim = MaxDimDefault
) (
  input  logic                   clk_i,
  input  logic [CfgWidth-1:0]    width_cfg_i,
  input  logic [CfgWidth-1:0]    height_cfg_i,
  input  logic [ModeWidth-1:0]   mode_i,
  input  logic [IndexWidth-1:0]  index_i,
  input  cmd_e                   cmd_i,
  output dp_status_t             status_o,
  output logic [CoordWidth-1:0]  row_o,
  output logic [CoordWidth-1:0]  col_o
);

  localparam int unsigned DW = CfgWidth;       // dimension width (holds values up to 63)
  localparam int unsigned AW = 2 * CfgWidth;   // area width

  logic [DW-1:0] w, h, mn, mx;
  always_comb begin
    w = (width_cfg_i == '0) ? DW'(1) :
        (width_cfg_i > DW'(MaxDim)) ? DW'(MaxDim) : width_cfg_i;
    h = (height_cfg_i == '0) ? DW'(1) :
        (height_cfg_i > DW'(MaxDim)) ? DW'(MaxDim) : height_cfg_i;
    mn = (w < h) ? w : h;
    mx = (w > h) ? w : h;
  end

  // index registers
  logic [IndexWidth-1:0] idx_q, idx_d;
  // quotient / remainder or triangle search
  logic [IndexWidth-1:0] quo_q, quo_d, rem_q, rem_d;
  logic                  calc_q, calc_d;
  logic [1:0]            zsel_q, zsel_d;   // 0 divide-ish middle, 1 head, 2 tail
  logic [IndexWidth-1:0] tri_q, tri_d;     // tri(quo)
  // run walker
  logic [CoordWidth:0]   r_q, r_d, c_q, c_d;
  logic [CoordWidth:0]   cnt_q, cnt_d, cnt2_q, cnt2_d;
  logic                  seg2_q, seg2_d, err_q, err_d, single_q, single_d;

  logic [AW-1:0]         area, limit;
  logic [IndexWidth-1:0] mt;
  logic [AW-1:0]         mt_w;

  always_comb begin
    area = AW'(w) * AW'(h);
    mt_w = (AW'(mn) * (AW'(mn) + AW'(1))) >> 1;
    mt   = IndexWidth'(mt_w);
    case (mode_i)
      MODE_HORIZ, MODE_VERT, MODE_ZIG: limit = area;
      MODE_ROW:  limit = AW'(h);
      MODE_COL:  limit = AW'(w);
      MODE_DIAG: limit = AW'(w) + AW'(h) - AW'(1);
      MODE_MIRR, MODE_BOX: limit = AW'(mx);
      MODE_IBOX: limit = AW'(mn);
      default:   limit = '0;
    endcase
  end

  // zigzag result once search is finished
  logic [CoordWidth:0] zr, zc;
  logic [IndexWidth-1:0] dyz, dxz;
  always_comb begin
    dxz = quo_q;
    dyz = rem_q;
    zr = '0;
    zc = '0;
    case (zsel_q)
      2'd1: begin
        if (!dxz[0]) dyz = dxz - rem_q;
        zr = (CoordWidth+1)'(dyz);
        zc = (CoordWidth+1)'(dxz - dyz);
      end
      2'd2: begin
        if ((IndexWidth'(w) + IndexWidth'(h) - IndexWidth'(2) - dxz) % 2 == 0)
          dyz = dxz - rem_q;
        zr = (CoordWidth+1)'(IndexWidth'(h) - IndexWidth'(1) - dyz);
        zc = (CoordWidth+1)'(IndexWidth'(w) - IndexWidth'(1) - (dxz - dyz));
      end
      default: begin
        // middle band: dx = quo, dy = mn - rem
        dyz = IndexWidth'(mn) - rem_q;
        if (((quo_q + IndexWidth'(mn)) % 2) == 0) dyz = IndexWidth'(mn) - dyz + 1'b1;
        if (w < h) begin
          dyz = IndexWidth'(mn) - dyz + 1'b1;
          zr = (CoordWidth+1)'(quo_q + dyz);
          zc = (CoordWidth+1)'(IndexWidth'(w) - dyz);
        end else begin
          zr = (CoordWidth+1)'(IndexWidth'(h) - dyz);
          zc = (CoordWidth+1)'(quo_q + dyz);
        end
      end
    endcase
  end

  logic [IndexWidth:0] tri_next;
  logic [IndexWidth-1:0] dvs;
  always_comb begin
    tri_next = {1'b0, tri_q} + {1'b0, quo_q} + 1'b1;
    dvs = (mode_i == MODE_VERT) ? IndexWidth'(h) :
          (mode_i == MODE_HORIZ) ? IndexWidth'(w) : IndexWidth'(mn);
  end

  logic [IndexWidth-1:0] i_ext;
  logic [CoordWidth:0]   i6;
  always_comb begin
    idx_d = idx_q; quo_d = quo_q; rem_d = rem_q; calc_d = calc_q; zsel_d = zsel_q;
    tri_d = tri_q; r_d = r_q; c_d = c_q; cnt_d = cnt_q; cnt2_d = cnt2_q;
    seg2_d = seg2_q; err_d = err_q; single_d = single_q;
    i_ext = index_i;
    i6 = (CoordWidth+1)'(index_i);
    case (cmd_i)
      CMD_LOAD: begin
        idx_d = index_i; err_d = (AW'(index_i) >= limit); seg2_d = 1'b0;
        single_d = 1'b0; calc_d = 1'b0; quo_d = '0; tri_d = '0; rem_d = index_i;
        zsel_d = 2'd0; r_d = '0; c_d = '0; cnt_d = '0; cnt2_d = '0;
        if (!err_d) begin
          case (mode_i)
            MODE_HORIZ, MODE_VERT: begin
              single_d = 1'b1; calc_d = 1'b1;
            end
            MODE_ZIG: begin
              single_d = 1'b1; calc_d = 1'b1;
              if (i_ext < mt) begin
                zsel_d = 2'd1; rem_d = i_ext;
              end else if (IndexWidth'(area - AW'(i_ext)) <= mt) begin
                zsel_d = 2'd2; rem_d = IndexWidth'(area - AW'(i_ext) - AW'(1));
              end else begin
                zsel_d = 2'd0; rem_d = i_ext - mt;
              end
            end
            MODE_ROW: begin
              r_d = i6; c_d = '0; cnt_d = (CoordWidth+1)'(w);
            end
            MODE_COL: begin
              r_d = '0; c_d = i6; cnt_d = (CoordWidth+1)'(h);
            end
            MODE_DIAG: begin
              r_d = (i_ext < IndexWidth'(h)) ? i6 : (CoordWidth+1)'(h - 1'b1);
              c_d = (CoordWidth+1)'(i_ext - IndexWidth'(r_d));
              // cells until row wraps below 0 or col reaches w
              cnt_d = ((r_d + 1'b1) < ((CoordWidth+1)'(w) - c_d)) ?
                      (r_d + 1'b1) : ((CoordWidth+1)'(w) - c_d);
            end
            MODE_MIRR: begin
              if (index_i == '0) begin
                cnt_d = (CoordWidth+1)'(mn);
              end else begin
                if (i_ext < IndexWidth'(w)) begin
                  cnt_d = ((CoordWidth+1)'(h) < ((CoordWidth+1)'(w) - i6)) ?
                          (CoordWidth+1)'(h) : ((CoordWidth+1)'(w) - i6);
                end
                if (i_ext < IndexWidth'(h)) begin
                  cnt2_d = ((CoordWidth+1)'(w) < ((CoordWidth+1)'(h) - i6)) ?
                           (CoordWidth+1)'(w) : ((CoordWidth+1)'(h) - i6);
                end
              end
            end
            MODE_BOX: begin
              c_d = i6;
              if (i_ext < IndexWidth'(w))
                cnt_d = (i_ext < IndexWidth'(h)) ? i6 : (CoordWidth+1)'(h);
              if (i_ext < IndexWidth'(h))
                cnt2_d = (i_ext < IndexWidth'(w)) ? i6 + 1'b1 : (CoordWidth+1)'(w);
            end
            default: begin // ibox
              r_d = i6; c_d = i6;
              cnt_d = (CoordWidth+1)'(w) - i6;
              cnt2_d = (CoordWidth+1)'(h) - i6;
            end
          endcase
          // mirror and box with empty first segment start in the second
          if ((mode_i == MODE_MIRR || mode_i == MODE_BOX) && cnt_d == '0) begin
            cnt_d = cnt2_d; cnt2_d = '0; seg2_d = 1'b1;
          end
          if (mode_i == MODE_MIRR && index_i != '0) begin
            if (!seg2_d) begin
              r_d = cnt_d - 1'b1; c_d = cnt_d - 1'b1 + i6;
            end else begin
              r_d = cnt_d - 1'b1 + i6; c_d = cnt_d - 1'b1;
            end
          end else if (mode_i == MODE_MIRR) begin
            r_d = '0; c_d = '0;
          end
          if (mode_i == MODE_BOX && seg2_d) begin
            r_d = i6; c_d = '0;
          end
        end
      end
      CMD_STEP: begin
        // a step after the calculation finished leaves everything as it is
        if (calc_q) begin
          if (zsel_q == 2'd0 || mode_i == MODE_HORIZ || mode_i == MODE_VERT) begin
            // divide by repeated subtraction, quotient below 32
            if (rem_q >= dvs) begin
              rem_d = rem_q - dvs; quo_d = quo_q + 1'b1;
            end else begin
              calc_d = 1'b0;
            end
          end else begin
            // inverse triangular number: largest k with tri(k) <= n
            if (tri_next <= {1'b0, rem_q}) begin
              quo_d = quo_q + 1'b1; tri_d = IndexWidth'(tri_next);
            end else begin
              rem_d = rem_q - tri_q; calc_d = 1'b0;
            end
          end
        end
      end
      CMD_EMIT: begin
        cnt_d = cnt_q - 1'b1;
        case (mode_i)
          MODE_ROW: c_d = c_q + 1'b1;
          MODE_COL: r_d = r_q + 1'b1;
          MODE_DIAG: begin
            r_d = r_q - 1'b1; c_d = c_q + 1'b1;
          end
          MODE_MIRR: begin
            if (idx_q == '0) begin
              r_d = r_q + 1'b1; c_d = c_q + 1'b1;
            end else begin
              r_d = r_q - 1'b1; c_d = c_q - 1'b1;
            end
          end
          MODE_BOX: begin
            if (seg2_q) c_d = c_q + 1'b1; else r_d = r_q + 1'b1;
          end
          default: begin
            if (seg2_q) r_d = r_q + 1'b1; else c_d = c_q + 1'b1;
          end
        endcase
      end
      CMD_PHASE: begin
        seg2_d = 1'b1; cnt_d = cnt2_q; cnt2_d = '0;
        case (mode_i)
          MODE_MIRR: begin
            r_d = cnt2_q - 1'b1 + (CoordWidth+1)'(idx_q);
            c_d = cnt2_q - 1'b1;
          end
          MODE_BOX: begin
            r_d = (CoordWidth+1)'(idx_q); c_d = '0;
          end
          default: begin
            r_d = (CoordWidth+1)'(idx_q); c_d = (CoordWidth+1)'(idx_q);
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; quo_q <= quo_d; rem_q <= rem_d; calc_q <= calc_d;
    zsel_q <= zsel_d; tri_q <= tri_d; r_q <= r_d; c_q <= c_d;
    cnt_q <= cnt_d; cnt2_q <= cnt2_d; seg2_q <= seg2_d; err_q <= err_d;
    single_q <= single_d;
  end

  always_comb begin
    status_o.busy_calc = calc_q;
    status_o.seg_done  = (cnt_q <= (CoordWidth+1)'(1));
    status_o.has_seg2  = (cnt2_q != '0);
    status_o.in_seg2   = seg2_q;
    status_o.error     = err_q;
    status_o.single    = single_q;
    row_o = '0;
    col_o = '0;
    if (err_q) begin
      row_o = '0; col_o = '0;
    end else if (single_q) begin
      case (mode_i)
        MODE_HORIZ: begin
          row_o = CoordWidth'(quo_q); col_o = CoordWidth'(rem_q);
        end
        MODE_VERT: begin
          row_o = CoordWidth'(rem_q); col_o = CoordWidth'(quo_q);
        end
        default: begin
          row_o = CoordWidth'(zr); col_o = CoordWidth'(zc);
        end
      endcase
    end else begin
      row_o = CoordWidth'(r_q); col_o = CoordWidth'(c_q);
    end
  end

endmodule

// File: hdl/fscg_ctrl.sv
// fscg_ctrl: sequencer for load, iterative calc and run emission
// depends on fscg_pkg
module fscg_ctrl
  import fscg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_last_o,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_CALC = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   last;

  always_comb begin
    last = status_i.error || status_i.single ||
           (status_i.seg_done && !status_i.has_seg2);
  end

  always_comb begin
    state_d = state_q;
    cmd_o = CMD_NONE;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    out_last_o = last;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = CMD_LOAD;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = status_i.busy_calc ? ST_CALC : ST_EMIT;
      end
      ST_CALC: begin
        cmd_o = CMD_STEP;
        if (!status_i.busy_calc) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last) begin
            state_d = ST_IDLE;
          end else if (status_i.seg_done) begin
            cmd_o = CMD_PHASE;
          end else begin
            cmd_o = CMD_EMIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/frequency_scan_coordinate_generator.sv
// frequency_scan_coordinate_generator: top level, config registers and channel glue
// depends on fscg_pkg, fscg_if, fscg_ctrl, fscg_datapath
//
// Maps a scan index to the coefficient coordinates it covers for the configured
// block width, height and scan mode. One index is handled at a time: it is taken
// in the idle cycle, a set-up state follows, then division (raster modes, zigzag
// middle band) or the inverse-triangle search (zigzag corners) runs one step per
// cycle, then coordinates leave one per cycle while the sink is ready, up to 64
// for an inverse box run. An index beyond the mode's range gives one result with
// index_error set. Configuration writes belong between runs, while idle.
module frequency_scan_coordinate_generator
  import fscg_pkg::*;
#(
  parameter int unsigned MaxDim = MaxDimDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  fscg_if.sink                   in_if,
  fscg_if.source                 out_if
);

  logic [CfgWidth-1:0]  width_q, height_q;
  logic [ModeWidth-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= CfgWidth'(32);
      height_q <= CfgWidth'(32);
      mode_q <= MODE_ZIG;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_MODE:   mode_q <= cfg_data_i[ModeWidth-1:0];
        default: ;
      endcase
    end
  end

  cmd_e                  cmd;
  dp_status_t            status;
  logic [CoordWidth-1:0] row, col;
  logic                  last;

  fscg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_last_o  (last),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fscg_datapath #(.MaxDim(MaxDim)) u_dp (
    .clk_i        (clk_i),
    .width_cfg_i  (width_q),
    .height_cfg_i (height_q),
    .mode_i       (mode_q),
    .index_i      (in_if.payload.scan_index),
    .cmd_i        (cmd),
    .status_o     (status),
    .row_o        (row),
    .col_o        (col)
  );

  assign out_if.payload.coord_row   = row;
  assign out_if.payload.coord_col   = col;
  assign out_if.payload.run_last    = last;
  assign out_if.payload.index_error = status.error;

endmodule

// File: tb/sv/frequency_scan_coordinate_generator_tb.sv
// frequency_scan_coordinate_generator_tb: self-checking bench for the scan coordinate generator
// depends on fscg_pkg, fscg_if and the frequency_scan_coordinate_generator top level
`timescale 1ns / 1ps

module frequency_scan_coordinate_generator_tb
  import fscg_pkg::*;
;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = CFG_WIDTH;
  logic [CfgWidth-1:0] cfg_data_i = '0;

  fscg_if #(.payload_t(scan_req_t)) in_ch ();
  fscg_if #(.payload_t(coord_t)) out_ch ();

  frequency_scan_coordinate_generator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  logic [IndexWidth-1:0] index_pend_q[$];
  coord_t coord_expect_q[$];
  int mismatches = 0;
  int coords_seen = 0;
  int indexes_sent = 0;
  int phases = 0;
  bit no_idle = 1'b0;

  // shadow registers as the block sees them
  logic [CfgWidth-1:0] shadow_width = 6'd32;
  logic [CfgWidth-1:0] shadow_height = 6'd32;
  logic [ModeWidth-1:0] shadow_mode = MODE_ZIG;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int tri_num(int k);
    return k * (k + 1) / 2;
  endfunction

  function automatic int tri_root(int n);
    int k;
    k = 0;
    while (tri_num(k + 1) <= n) k++;
    return k;
  endfunction

  function automatic void push_coord(int r, int c);
    coord_t e;
    e.coord_row = r[CoordWidth-1:0];
    e.coord_col = c[CoordWidth-1:0];
    e.run_last = 1'b0;
    e.index_error = 1'b0;
    coord_expect_q.push_back(e);
  endfunction

  // expected coordinates for one index under the shadow configuration
  function automatic void predict_coords(int i);
    int w, h, mn, mx, lim, k, r, c, dx, dy, mt, j, len, row, col, n0;
    coord_t e;
    w = (shadow_width == 0) ? 1 : (shadow_width > 32 ? 32 : int'(shadow_width));
    h = (shadow_height == 0) ? 1 : (shadow_height > 32 ? 32 : int'(shadow_height));
    mn = w < h ? w : h;
    mx = w > h ? w : h;
    n0 = coord_expect_q.size();
    case (shadow_mode)
      MODE_HORIZ, MODE_VERT, MODE_ZIG: lim = w * h;
      MODE_ROW: lim = h;
      MODE_COL: lim = w;
      MODE_DIAG: lim = w + h - 1;
      MODE_MIRR, MODE_BOX: lim = mx;
      MODE_IBOX: lim = mn;
      default: lim = 0;
    endcase
    if (i >= lim) begin
      e = '{coord_row: '0, coord_col: '0, run_last: 1'b1, index_error: 1'b1};
      coord_expect_q.push_back(e);
      return;
    end
    case (shadow_mode)
      MODE_HORIZ: push_coord(i / w, i % w);
      MODE_VERT: push_coord(i % h, i / h);
      MODE_ZIG: begin
        mt = tri_num(mn);
        if (i < mt) begin
          dx = tri_root(i);
          dy = i - tri_num(dx);
          if (dx % 2 == 0) dy = dx - dy;
          r = dy;
          c = dx - dy;
        end else if (w * h - i <= mt) begin
          j = w * h - i - 1;
          dx = tri_root(j);
          dy = j - tri_num(dx);
          if ((w + h - 2 - dx) % 2 == 0) dy = dx - dy;
          r = h - 1 - dy;
          c = w - 1 - (dx - dy);
        end else begin
          dx = (i - mt) / mn;
          dy = mn - ((i - mt) % mn);
          if ((dx + mn) % 2 == 0) dy = mn - dy + 1;
          if (w < h) begin
            dy = mn - dy + 1;
            r = dx + dy;
            c = w - dy;
          end else begin
            r = h - dy;
            c = dx + dy;
          end
        end
        push_coord(r, c);
      end
      MODE_ROW: for (k = 0; k < w; k++) push_coord(i, k);
      MODE_COL: for (k = 0; k < h; k++) push_coord(k, i);
      MODE_DIAG: begin
        row = (i < h ? i : h - 1) + 1;
        col = i - (row - 1);
        for (; row > 0 && col < w; row--, col++) push_coord(row - 1, col);
      end
      MODE_MIRR: begin
        if (i == 0) begin
          for (k = 0; k < mn; k++) push_coord(k, k);
        end else begin
          if (i < w) begin
            len = h < w - i ? h : w - i;
            for (k = len; k > 0; k--) push_coord(k - 1, k + i - 1);
          end
          if (i < h) begin
            len = w < h - i ? w : h - i;
            for (k = len; k > 0; k--) push_coord(k + i - 1, k - 1);
          end
        end
      end
      MODE_BOX: begin
        if (i < w) for (k = 0; k < (i < h ? i : h); k++) push_coord(k, i);
        if (i < h) for (k = 0; k < (i < w ? i + 1 : w); k++) push_coord(i, k);
      end
      default: begin
        for (k = i; k < w; k++) push_coord(i, k);
        for (k = i; k < h; k++) push_coord(k, i);
      end
    endcase
    if (coord_expect_q.size() > n0)
      coord_expect_q[coord_expect_q.size() - 1].run_last = 1'b1;
  endfunction

  function automatic int scan_limit();
    int w, h;
    w = (shadow_width == 0) ? 1 : (shadow_width > 32 ? 32 : int'(shadow_width));
    h = (shadow_height == 0) ? 1 : (shadow_height > 32 ? 32 : int'(shadow_height));
    case (shadow_mode)
      MODE_HORIZ, MODE_VERT, MODE_ZIG: return w * h;
      MODE_ROW: return h;
      MODE_COL: return w;
      MODE_DIAG: return w + h - 1;
      MODE_MIRR, MODE_BOX: return w > h ? w : h;
      MODE_IBOX: return w < h ? w : h;
      default: return 1;
    endcase
  endfunction

  task automatic send_index(int i);
    predict_coords(i);
    index_pend_q.push_back(i[IndexWidth-1:0]);
    indexes_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_WIDTH: shadow_width = val;
      CFG_HEIGHT: shadow_height = val;
      default: shadow_mode = val[ModeWidth-1:0];
    endcase
  endtask

  task automatic drain();
    wait (index_pend_q.size() == 0 && coord_expect_q.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_config(int w, int h, logic [ModeWidth-1:0] m);
    drain();
    write_reg(CFG_WIDTH, w[CfgWidth-1:0]);
    write_reg(CFG_HEIGHT, h[CfgWidth-1:0]);
    write_reg(CFG_MODE, {2'b00, m});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  // sender: one index per transaction, random gaps
  always @(posedge clk_i) begin
    if (rst_ni && (!in_ch.valid || in_ch.ready)) begin
      if (index_pend_q.size() > 0 && (no_idle || $urandom_range(99) >= 37)) begin
        in_ch.valid <= 1'b1;
        in_ch.payload.scan_index <= index_pend_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, compare each coordinate with the oldest expectation
  always @(posedge clk_i) begin
    coord_t exp_c;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        coords_seen++;
        if (coord_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected coordinate row=%0d col=%0d last=%0b err=%0b",
                     out_ch.payload.coord_row, out_ch.payload.coord_col,
                     out_ch.payload.run_last, out_ch.payload.index_error);
        end else begin
          exp_c = coord_expect_q.pop_front();
          if (out_ch.payload !== exp_c) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected row=%0d col=%0d last=%0b err=%0b, got %0d %0d %0b %0b",
                       exp_c.coord_row, exp_c.coord_col, exp_c.run_last, exp_c.index_error,
                       out_ch.payload.coord_row, out_ch.payload.coord_col,
                       out_ch.payload.run_last, out_ch.payload.index_error);
          end
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 37);
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int w, h, lim, n, k, m;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: 32x32 zigzag
    send_index(0);
    send_index(1);
    send_index(528);
    send_index(1023);
    for (m = 0; m <= 8; m++) begin
      set_config(32, 32, m[ModeWidth-1:0]);
      send_index(0);
      send_index(31);
      send_index(32);
    end
    // clamped dimensions, undefined mode, zigzag corner regions on a non-square block
    set_config(0, 63, MODE_IBOX);
    send_index(0);
    send_index(1);
    set_config(5, 3, MODE_ZIG);
    for (k = 0; k < 16; k++) send_index(k);
    set_config(3, 7, 4'd15);
    send_index(0);

    // random phases, mostly in-range indexes with a few wild ones
    while (indexes_sent < 400) begin
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(63);
        h = $urandom_range(63);
      end else begin
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 9);
      end
      m = ($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(8);
      set_config(w, h, m[ModeWidth-1:0]);
      no_idle = (phases % 7 == 3);
      lim = scan_limit();
      n = $urandom_range(8, 30);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(9) < 8) send_index($urandom_range(lim - 1));
        else send_index($urandom_range(1023));
      end
    end
    set_config(32, 32, MODE_ZIG);
    no_idle = 1'b0;

    $display("covered %0d scan indexes over %0d register settings, %0d coordinates checked",
             indexes_sent, phases, coords_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
